[sv/mdcl_pkg.sv]
package mdcl_pkg;

    localparam logic [1:0] OP_DRIVE      = 2'd0;
    localparam logic [1:0] OP_RAMP       = 2'd1;
    localparam logic [1:0] OP_RAMP_CLEAR = 2'd2;
    localparam logic [1:0] OP_TABLE_WR   = 2'd3;

    localparam logic [3:0] REG_LIMIT_MODE  = 4'd0;
    localparam logic [3:0] REG_PERF_MODE   = 4'd1;
    localparam logic [3:0] REG_ROLL_EN     = 4'd2;
    localparam logic [3:0] REG_RAMP_EN     = 4'd3;
    localparam logic [3:0] REG_DEADZONE    = 4'd4;
    localparam logic [3:0] REG_MAX_SCALE   = 4'd5;
    localparam logic [3:0] REG_RAMP_STEP   = 4'd6;
    localparam logic [3:0] REG_POWER_RATIO = 4'd7;

    localparam logic [1:0] MODE_STEPS     = 2'd0;
    localparam logic [1:0] MODE_PIECEWISE = 2'd1;

    localparam logic [16:0] FULL     = 17'd32768;
    localparam logic [15:0] NO_LIMIT = 16'hFFFF;
    localparam logic [6:0]  PEDAL_MAX = 7'd100;

    // Reciprocals: x/10 as (x*52429)>>19, x/100 as (x*5368710)>>29,
    // interpolation spans as (x*K)>>24
    localparam logic [23:0] RECIP_10   = 24'd52429;
    localparam logic [23:0] RECIP_100  = 24'd5368710;
    localparam logic [23:0] RECIP_S30  = 24'd559241;
    localparam logic [23:0] RECIP_S75  = 24'd223697;
    localparam logic [23:0] RECIP_S15  = 24'd1118482;
    localparam logic [23:0] ROUND_Q15  = 24'd16384;

    localparam int unsigned MUL_W = 24;
    localparam int unsigned PROD_W = 48;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
        logic [MUL_W-1:0] c;
    } t_mul_req;

endpackage

[sv/motor_drive_current_limiter.sv]
// Motor drive current limiter. Each input transaction carries one operation:
// op 0 computes the drive current (pedal deadzone, rollover limit from a
// loaded speed table indexed by |steer|/10, speed limit by mode) and the power
// current; op 1 ramps the level toward the target, rising by at most
// ramp_step while ramping is enabled, else taking the target at once;
// op 2 clears the ramp; op 3 writes one rollover table entry. Every
// transaction gives exactly one result transaction. Op 0 makes six passes
// through the single shared 24x24 multiply-add unit (steer/10, pedal/100,
// interpolation product, span reciprocal, drive scale, power scale).
// The input is not ready while an item is in work. A finished result sits in
// an output register, so the next transaction is taken while it waits. The
// rollover table holds no reset value: read only entries that were written.
// Configuration is taken every cycle and must be written only while idle.
module motor_drive_current_limiter
    import mdcl_pkg::*;
#(
    parameter int ROLLOVER_LAST_INDEX = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_motor_rpm,
    input  logic [15:0] i_velocity_cms,
    input  logic [15:0] i_steer_angle,
    input  logic [7:0]  i_pedal_percent,
    input  logic [15:0] i_target_current,
    input  logic [6:0]  i_table_index,
    input  logic [15:0] i_table_speed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_drive_current,
    output logic [15:0] o_limit_fraction,
    output logic        o_rollover_active,
    output logic [15:0] o_power_current,
    output logic [15:0] o_ramped_current,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int DEPTH = ROLLOVER_LAST_INDEX + 1;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PED  = 3'd1;
    localparam logic [2:0] S_INT1 = 3'd2;
    localparam logic [2:0] S_INT2 = 3'd3;
    localparam logic [2:0] S_DRV  = 3'd4;
    localparam logic [2:0] S_PWR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    // configuration
    logic [1:0]  r_limit_mode;
    logic        r_perf_mode, r_roll_en, r_ramp_en;
    logic [6:0]  r_deadzone;
    logic [15:0] r_max_scale, r_ramp_step, r_power_ratio;

    // control and state
    logic [2:0]  r_state, n_state;
    logic [1:0]  r_op;
    logic        r_flag;
    logic [15:0] r_level;
    logic        r_out_valid;

    // working registers
    logic [16:0] r_rpm_abs, r_vel_abs;
    logic [6:0]  r_ped_pct;
    logic [16:0] r_pedal, r_lim, r_drive;
    logic        r_roll_full;
    logic [16:0] r_seg_base;
    logic        r_seg_neg;
    logic [23:0] r_seg_k;

    // output registers
    logic [15:0] r_o_drive, r_o_lim, r_o_pwr, r_o_ramp;
    logic        r_o_roll;

    logic              in_acc, out_free;
    t_mul_req          mul_req;
    logic [PROD_W-1:0] prod;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [15:0]       ram_rdata;

    logic [16:0] steer_abs, rpm_abs_in, vel_abs_in;
    logic [6:0]  ped_clamp;
    logic [12:0] idx_full;
    logic [16:0] tgt_sat, step_sat, ramp_up, scale_sat, ratio_sat;
    logic [16:0] step_frac, interp, lim_val, m_min;
    logic [16:0] q_seg;

    function automatic logic [16:0] abs16(input logic [15:0] v);
        abs16 = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

    function automatic logic [16:0] sat_full(input logic [15:0] v);
        sat_full = ({1'b0, v} > FULL) ? FULL : {1'b0, v};
    endfunction

    mdcl_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    mdcl_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_table_speed),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign steer_abs  = abs16(i_steer_angle);
    assign rpm_abs_in = abs16(i_motor_rpm);
    assign vel_abs_in = abs16(i_velocity_cms);
    assign ped_clamp  = (i_pedal_percent > 8'(PEDAL_MAX)) ? PEDAL_MAX : i_pedal_percent[6:0];
    assign tgt_sat    = sat_full(i_target_current);
    assign step_sat   = sat_full(r_ramp_step);
    assign ramp_up    = {1'b0, r_level} + step_sat;
    assign scale_sat  = sat_full(r_max_scale);
    assign ratio_sat  = sat_full(r_power_ratio);

    // table write: drop indexes beyond the last entry
    assign ram_we    = in_acc && (i_op == OP_TABLE_WR) &&
                       (10'(i_table_index) <= 10'(ROLLOVER_LAST_INDEX));
    assign ram_waddr = AW'(i_table_index);

    // clamp the steering index to the last entry
    assign idx_full  = prod[19 +: 13];
    assign ram_re    = (r_state == S_PED);
    assign ram_raddr = (idx_full > 13'(ROLLOVER_LAST_INDEX)) ?
                       AW'(ROLLOVER_LAST_INDEX) : AW'(idx_full);

    // speed steps
    always_comb begin
        step_frac = FULL;
        if (r_vel_abs >= 17'd313)  step_frac = 17'd26214;
        if (r_vel_abs >= 17'd760)  step_frac = 17'd24576;
        if (r_vel_abs >= 17'd895)  step_frac = 17'd22938;
        if (r_vel_abs >= 17'd1029) step_frac = 17'd19661;
        if (r_vel_abs >= 17'd1118) step_frac = 17'd16384;
        if (r_vel_abs >= 17'd1275) step_frac = 17'd14746;
    end

    assign q_seg  = prod[24 +: 17];
    assign interp = r_seg_neg ? (r_seg_base - q_seg) : (r_seg_base + q_seg);

    always_comb begin
        if (r_perf_mode) begin
            lim_val = FULL;
        end else if (r_limit_mode == MODE_STEPS) begin
            lim_val = step_frac;
        end else if (r_limit_mode == MODE_PIECEWISE) begin
            lim_val = interp;
        end else begin
            lim_val = FULL;
        end
        m_min = r_roll_full ? r_pedal : 17'd0;
        if (r_limit_mode < 2'd2 && lim_val < m_min) begin
            m_min = lim_val;
        end
    end

    // sequencer and multiplier issue
    always_comb begin
        n_state = r_state;
        mul_req = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_op == OP_DRIVE) ? S_PED : S_DONE;
                    mul_req = '{en: 1'b1, a: 24'(steer_abs), b: RECIP_10, c: 24'd0};
                end
            end
            S_PED: begin
                n_state = S_INT1;
                mul_req = '{en: 1'b1, a: {2'b0, r_ped_pct, 15'd50}, b: RECIP_100, c: 24'd0};
                mul_req.a = 24'({r_ped_pct, 15'd0}) + 24'd50;
            end
            S_INT1: begin
                n_state = S_INT2;
                mul_req.en = 1'b1;
                if (r_rpm_abs > 17'd120 && r_rpm_abs <= 17'd150) begin
                    mul_req.a = 24'(r_rpm_abs - 17'd120);
                    mul_req.b = 24'd8192;
                    mul_req.c = 24'd15;
                end else if (r_rpm_abs > 17'd150 && r_rpm_abs <= 17'd225) begin
                    mul_req.a = 24'(r_rpm_abs - 17'd150);
                    mul_req.b = 24'd983;
                    mul_req.c = 24'd37;
                end else if (r_rpm_abs > 17'd225 && r_rpm_abs <= 17'd240) begin
                    mul_req.a = 24'(r_rpm_abs - 17'd225);
                    mul_req.b = 24'd2294;
                    mul_req.c = 24'd7;
                end
            end
            S_INT2: begin
                n_state = S_DRV;
                mul_req = '{en: 1'b1, a: prod[23:0], b: r_seg_k, c: 24'd0};
            end
            S_DRV: begin
                n_state = S_PWR;
                mul_req = '{en: 1'b1, a: 24'(scale_sat), b: 24'(m_min), c: ROUND_Q15};
            end
            S_PWR: begin
                n_state = S_DONE;
                mul_req = '{en: 1'b1, a: 24'(r_pedal), b: 24'(ratio_sat), c: ROUND_Q15};
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_limit_mode  <= 2'd0;
            r_perf_mode   <= 1'b0;
            r_roll_en     <= 1'b1;
            r_ramp_en     <= 1'b1;
            r_deadzone    <= 7'd5;
            r_max_scale   <= 16'd32768;
            r_ramp_step   <= 16'd328;
            r_power_ratio <= 16'd32768;
            r_flag        <= 1'b0;
            r_level       <= 16'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_LIMIT_MODE:  r_limit_mode  <= i_cfg_data[1:0];
                    REG_PERF_MODE:   r_perf_mode   <= i_cfg_data[0];
                    REG_ROLL_EN:     r_roll_en     <= i_cfg_data[0];
                    REG_RAMP_EN:     r_ramp_en     <= i_cfg_data[0];
                    REG_DEADZONE:    r_deadzone    <= i_cfg_data[6:0];
                    REG_MAX_SCALE:   r_max_scale   <= i_cfg_data;
                    REG_RAMP_STEP:   r_ramp_step   <= i_cfg_data;
                    REG_POWER_RATIO: r_power_ratio <= i_cfg_data;
                    default: ;
                endcase
            end

            // ramp updates at acceptance; it falls at once, rises by at most a step when enabled
            if (in_acc && i_op == OP_RAMP) begin
                if (r_ramp_en && ramp_up < tgt_sat) begin
                    r_level <= ramp_up[15:0];
                end else begin
                    r_level <= tgt_sat[15:0];
                end
            end else if (in_acc && i_op == OP_RAMP_CLEAR) begin
                r_level <= 16'd0;
            end

            // rollover flag from the table entry
            if (r_state == S_INT1) begin
                r_flag <= r_roll_en && (ram_rdata != NO_LIMIT) &&
                          (r_vel_abs > {1'b0, ram_rdata});
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= i_op;
            r_rpm_abs <= rpm_abs_in;
            r_vel_abs <= vel_abs_in;
            r_ped_pct <= ped_clamp;
        end
        if (r_state == S_INT1) begin
            r_pedal     <= (r_ped_pct > r_deadzone) ? prod[29 +: 17] : 17'd0;
            r_roll_full <= !(r_roll_en && (ram_rdata != NO_LIMIT) &&
                             (r_vel_abs > {1'b0, ram_rdata}));
            if (r_rpm_abs <= 17'd120) begin
                r_seg_base <= FULL;
                r_seg_neg  <= 1'b0;
                r_seg_k    <= RECIP_S30;
            end else if (r_rpm_abs <= 17'd150) begin
                r_seg_base <= FULL;
                r_seg_neg  <= 1'b1;
                r_seg_k    <= RECIP_S30;
            end else if (r_rpm_abs <= 17'd225) begin
                r_seg_base <= 17'd24576;
                r_seg_neg  <= 1'b0;
                r_seg_k    <= RECIP_S75;
            end else if (r_rpm_abs <= 17'd240) begin
                r_seg_base <= 17'd25559;
                r_seg_neg  <= 1'b0;
                r_seg_k    <= RECIP_S15;
            end else begin
                r_seg_base <= 17'd27853;
                r_seg_neg  <= 1'b0;
                r_seg_k    <= RECIP_S15;
            end
        end
        if (r_state == S_DRV) begin
            r_lim <= lim_val;
        end
        if (r_state == S_PWR) begin
            r_drive <= prod[15 +: 17];
        end
        if (r_state == S_DONE && out_free) begin
            r_o_roll <= r_flag;
            r_o_ramp <= r_level;
            if (r_op == OP_DRIVE) begin
                r_o_drive <= r_drive[15:0];
                r_o_lim   <= r_lim[15:0];
                r_o_pwr   <= prod[30:15];
            end else begin
                r_o_drive <= 16'd0;
                r_o_lim   <= 16'd0;
                r_o_pwr   <= 16'd0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_current   = r_o_drive;
    assign o_limit_fraction  = r_o_lim;
    assign o_rollover_active = r_o_roll;
    assign o_power_current   = r_o_pwr;
    assign o_ramped_current  = r_o_ramp;
endmodule

[sv/mdcl_ram.sv]
module mdcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/mdcl_mul.sv]
module mdcl_mul
    import mdcl_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);
    logic [PROD_W-1:0] r_prod;

    // product plus addend, held until the next issue
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b) + PROD_W'(i_req.c);
        end
    end

    assign o_prod = r_prod;
endmodule

[sv/mdcl_checker.sv]
module mdcl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_drive_current,
    input logic [15:0] o_power_current,
    input logic [15:0] o_ramped_current
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive_current))
        else $error("result dropped or changed while stalled");

    // one transaction in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after acceptance");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_drive_current <= 16'd32768 && o_power_current <= 16'd32768)
        else $error("current above full scale");

    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_ramped_current <= 16'd32768)
        else $error("ramp level above full scale");
endmodule

bind motor_drive_current_limiter mdcl_checker u_mdcl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_drive_current  (o_drive_current),
    .o_power_current  (o_power_current),
    .o_ramped_current (o_ramped_current)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mdcl_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] rpm;
        logic [15:0] vel;
        logic [15:0] steer;
        logic [7:0]  pedal;
        logic [15:0] target;
        logic [6:0]  tidx;
        logic [15:0] tspeed;
    } t_drive_cmd;

    typedef struct {
        logic [15:0] drive;
        logic [15:0] limit;
        logic        roll;
        logic [15:0] power;
        logic [15:0] ramp;
    } t_drive_res;

    typedef struct {
        logic [3:0]  idx;
        logic [15:0] data;
    } t_reg_write;

    localparam int LAST_IDX = 127;
    localparam int STEP_CMS [6] = '{313, 760, 895, 1029, 1118, 1275};
    localparam int STEP_FRAC[6] = '{26214, 24576, 22938, 19661, 16384, 14746};
    localparam longint KNOT_RPM [5] = '{0, 120, 150, 225, 240};
    localparam longint KNOT_FRAC[5] = '{32768, 32768, 24576, 25559, 27853};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = OP_DRIVE;
    logic [15:0] i_motor_rpm = '0;
    logic [15:0] i_velocity_cms = '0;
    logic [15:0] i_steer_angle = '0;
    logic [7:0]  i_pedal_percent = '0;
    logic [15:0] i_target_current = '0;
    logic [6:0]  i_table_index = '0;
    logic [15:0] i_table_speed = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_drive_current;
    logic [15:0] o_limit_fraction;
    logic        o_rollover_active;
    logic [15:0] o_power_current;
    logic [15:0] o_ramped_current;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    motor_drive_current_limiter dut (.*);

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: configuration shadow and block state
    int unsigned limit_mode = 0, perf_mode = 0, roll_en = 1, ramp_en = 1;
    int unsigned deadzone = 5, max_scale = 32768, ramp_step = 328, power_ratio = 32768;
    int unsigned speed_table[LAST_IDX+1];
    int unsigned ramp_level = 0;
    int unsigned roll_flag = 0;

    t_drive_cmd pending_cmds[$];
    t_drive_res expected_results[$];
    t_reg_write pending_writes[$];
    int errors = 0;
    bit no_gaps = 0;
    int hold_trigger = 0;

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int unsigned abs16(logic [15:0] x);
        return x[15] ? 32'h10000 - x : x;
    endfunction

    function automatic int unsigned sat_full(int unsigned v);
        return v > 32768 ? 32768 : v;
    endfunction

    function automatic int unsigned q15_mul(int unsigned a, int unsigned b);
        return (a * b + 16384) >> 15;
    endfunction

    function automatic int unsigned interp_rpm(longint r);
        longint span, num, q;
        for (int i = 1; i < 5; i++) begin
            if (r <= KNOT_RPM[i]) begin
                span = KNOT_RPM[i] - KNOT_RPM[i-1];
                num = (r - KNOT_RPM[i-1]) * (KNOT_FRAC[i] - KNOT_FRAC[i-1]);
                q = num >= 0 ? (num + span / 2) / span : -((-num + span / 2) / span);
                return KNOT_FRAC[i-1] + q;
            end
        end
        return KNOT_FRAC[4];
    endfunction

    // Compute the result of one command and advance the block state
    function automatic t_drive_res predict_drive(t_drive_cmd c);
        t_drive_res r;
        int unsigned p, pedal, roll, lim, m, idx, v;
        r = '{default: '0};
        case (c.op)
            OP_DRIVE: begin
                p = c.pedal > 100 ? 100 : c.pedal;
                pedal = p <= deadzone ? 0 : (p * 32768 + 50) / 100;
                if (!roll_en) begin
                    roll_flag = 0;
                    roll = 32768;
                end else begin
                    idx = abs16(c.steer) / 10;
                    if (idx > LAST_IDX) idx = LAST_IDX;
                    if (speed_table[idx] != 65535 && abs16(c.vel) > speed_table[idx]) begin
                        roll_flag = 1;
                        roll = 0;
                    end else begin
                        roll_flag = 0;
                        roll = 32768;
                    end
                end
                m = pedal < roll ? pedal : roll;
                if (perf_mode) lim = 32768;
                else if (limit_mode == MODE_STEPS) begin
                    lim = 32768;
                    v = abs16(c.vel);
                    for (int i = 0; i < 6; i++)
                        if (v >= STEP_CMS[i]) lim = STEP_FRAC[i];
                end else if (limit_mode == MODE_PIECEWISE) lim = interp_rpm(abs16(c.rpm));
                else lim = 32768;
                if (limit_mode < 2 && lim < m) m = lim;
                r.drive = q15_mul(sat_full(max_scale), m);
                r.limit = lim;
                r.power = q15_mul(pedal, sat_full(power_ratio));
            end
            OP_RAMP: begin
                if (ramp_en) begin
                    v = ramp_level + sat_full(ramp_step);
                    ramp_level = sat_full(c.target) < v ? sat_full(c.target) : v;
                end else begin
                    ramp_level = sat_full(c.target);
                end
            end
            OP_RAMP_CLEAR: ramp_level = 0;
            default: speed_table[c.tidx] = c.tspeed;
        endcase
        r.roll = roll_flag;
        r.ramp = ramp_level;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned d;
        d = $urandom_range(0, 99);
        if (no_gaps || d < 60) return 0;
        if (d < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Command driver: hold the payload until accepted, then predict and advance
    int unsigned in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid)
                expected_results.push_back(predict_drive('{i_op, i_motor_rpm, i_velocity_cms,
                    i_steer_angle, i_pedal_percent, i_target_current, i_table_index,
                    i_table_speed}));
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                t_drive_cmd c;
                c = pending_cmds.pop_front();
                i_op <= c.op;
                i_motor_rpm <= c.rpm;
                i_velocity_cms <= c.vel;
                i_steer_angle <= c.steer;
                i_pedal_percent <= c.pedal;
                i_target_current <= c.target;
                i_table_index <= c.tidx;
                i_table_speed <= c.tspeed;
                i_in_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Register write driver; the shadow copy changes on the accepting edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (!i_cfg_valid || o_cfg_ready) begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_LIMIT_MODE:  limit_mode  = i_cfg_data[1:0];
                    REG_PERF_MODE:   perf_mode   = i_cfg_data[0];
                    REG_ROLL_EN:     roll_en     = i_cfg_data[0];
                    REG_RAMP_EN:     ramp_en     = i_cfg_data[0];
                    REG_DEADZONE:    deadzone    = i_cfg_data[6:0];
                    REG_MAX_SCALE:   max_scale   = i_cfg_data;
                    REG_RAMP_STEP:   ramp_step   = i_cfg_data;
                    REG_POWER_RATIO: power_ratio = i_cfg_data;
                    default: ;
                endcase
            end
            if (pending_writes.size() > 0) begin
                t_reg_write w;
                w = pending_writes.pop_front();
                i_cfg_index <= w.idx;
                i_cfg_data <= w.data;
                i_cfg_valid <= 1'b1;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // Result monitor: random back-pressure plus one long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result transaction", 1, 0);
            end else begin
                t_drive_res e;
                e = expected_results.pop_front();
                if (o_drive_current !== e.drive) report("drive_current", o_drive_current, e.drive);
                if (o_limit_fraction !== e.limit) report("limit_fraction", o_limit_fraction, e.limit);
                if (o_rollover_active !== e.roll) report("rollover_active", o_rollover_active, e.roll);
                if (o_power_current !== e.power) report("power_current", o_power_current, e.power);
                if (o_ramped_current !== e.ramp) report("ramped_current", o_ramped_current, e.ramp);
            end
        end
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (no_gaps) begin
            i_out_ready <= 1'b1;
        end else begin
            int unsigned d;
            d = $urandom_range(0, 99);
            if (d < 2) begin
                hold_left = $urandom_range(5, 30);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= d >= 25 || (d < 5 ? 1'b0 : $urandom_range(0, 1));
            end
        end
    end

    task automatic add_cmd(logic [1:0] op, logic [15:0] rpm, logic [15:0] vel,
                           logic [15:0] steer, logic [7:0] pedal, logic [15:0] target,
                           logic [6:0] tidx, logic [15:0] tspeed);
        pending_cmds.push_back('{op, rpm, vel, steer, pedal, target, tidx, tspeed});
    endtask

    task automatic add_random_cmd();
        int unsigned k;
        logic [15:0] vel, rpm, tspeed;
        logic [7:0] pedal;
        k = $urandom_range(0, 99);
        // Keep speeds mostly around the thresholds, sometimes full range
        vel = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1500);
        if ($urandom_range(0, 1)) vel = -vel;
        rpm = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
        if ($urandom_range(0, 1)) rpm = -rpm;
        pedal = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 110);
        tspeed = $urandom_range(0, 4) == 0 ? NO_LIMIT : $urandom_range(0, 1600);
        if ($urandom_range(0, 9) == 0) tspeed = $urandom;
        add_cmd(k < 70 ? OP_DRIVE : k < 85 ? OP_RAMP : k < 90 ? OP_RAMP_CLEAR : OP_TABLE_WR,
                rpm, vel, $urandom, pedal,
                $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 32768),
                $urandom, tspeed);
    endtask

    // Sample on the falling edge so driver updates of the same edge have settled
    task automatic drain();
        @(negedge i_clk);
        while (!(pending_cmds.size() == 0 && !i_in_valid && expected_results.size() == 0))
            @(negedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_regs(int unsigned mode, int unsigned perf, int unsigned roll,
                            int unsigned ramp, int unsigned dz, int unsigned scale,
                            int unsigned rstep, int unsigned ratio);
        drain();
        pending_writes.push_back('{REG_LIMIT_MODE, mode});
        pending_writes.push_back('{REG_PERF_MODE, perf});
        pending_writes.push_back('{REG_ROLL_EN, roll});
        pending_writes.push_back('{REG_RAMP_EN, ramp});
        pending_writes.push_back('{REG_DEADZONE, dz});
        pending_writes.push_back('{REG_MAX_SCALE, scale});
        pending_writes.push_back('{REG_RAMP_STEP, rstep});
        pending_writes.push_back('{REG_POWER_RATIO, ratio});
        wait (pending_writes.size() == 0 && !i_cfg_valid);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        repeat (n) add_random_cmd();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Load every table entry first so no drive transaction reads an unwritten one
        for (int i = 0; i <= LAST_IDX; i++)
            add_cmd(OP_TABLE_WR, 0, 0, 0, 0, 0, i,
                    i % 5 == 0 ? NO_LIMIT : $urandom_range(0, 1500));

        // Directed: deadzone edges, pedal saturation, steering and speed extremes
        add_cmd(OP_DRIVE, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_DRIVE, 0, 0, 0, 5, 0, 0, 0);
        add_cmd(OP_DRIVE, 0, 312, 0, 6, 0, 0, 0);
        add_cmd(OP_DRIVE, 0, 313, 9, 100, 0, 0, 0);
        add_cmd(OP_DRIVE, 0, -1275, -32768, 101, 0, 0, 0);
        add_cmd(OP_DRIVE, 0, -32768, 32767, 255, 0, 0, 0);
        add_cmd(OP_DRIVE, 0, 32767, 1270, 60, 0, 0, 0);
        add_cmd(OP_RAMP, 0, 0, 0, 0, 32768, 0, 0);
        add_cmd(OP_RAMP, 0, 0, 0, 0, 65535, 0, 0);
        add_cmd(OP_RAMP, 0, 0, 0, 0, 100, 0, 0);
        add_cmd(OP_RAMP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_TABLE_WR, 0, 0, 0, 0, 0, 127, NO_LIMIT);
        add_cmd(OP_TABLE_WR, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_DRIVE, 0, 1, 0, 50, 0, 0, 0);

        // Interpolation knots and neighbors, both signs
        set_regs(MODE_PIECEWISE, 0, 1, 1, 0, 32768, 328, 32768);
        foreach (KNOT_RPM[i]) begin
            add_cmd(OP_DRIVE, KNOT_RPM[i], 0, 20, 80, 0, 0, 0);
            add_cmd(OP_DRIVE, -(KNOT_RPM[i] + 1), 0, 20, 80, 0, 0, 0);
        end
        add_cmd(OP_DRIVE, -32768, 0, 20, 80, 0, 0, 0);

        no_gaps = 1;
        set_regs(MODE_STEPS, 0, 1, 1, 5, 32768, 328, 32768);
        random_phase(200);
        drain();
        no_gaps = 0;

        set_regs(MODE_PIECEWISE, 0, 0, 0, 0, 0, 0, 0);
        random_phase(200);

        set_regs(2, 1, 1, 1, 100, 65535, 65535, 65535);
        random_phase(200);

        set_regs(3, 0, 1, 1, 127, 20000, 32768, 16000);
        random_phase(200);

        // Hold the receiver off while commands keep coming so the block stalls
        set_regs(MODE_STEPS, 1, 1, 1, 10, 32767, 1000, 32768);
        hold_trigger++;
        random_phase(200);

        set_regs(MODE_PIECEWISE, 0, 1, 1, $urandom_range(0, 100), $urandom_range(0, 32768),
                 $urandom_range(0, 4000), $urandom_range(0, 32768));
        random_phase(200);

        set_regs(MODE_STEPS, 0, 1, 0, 0, 32768, 1, 32768);
        random_phase(150);

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
